FILE: src/mst_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_pkg: shared types and codes for the min-tracking stack
// Request and response beats, the stored entry layout and the status codes.
// ----------------------------------------------------------------------------
package mst_pkg;

   localparam int unsigned DataWidth  = 32;
   localparam int unsigned CountWidth = 7;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_OVERFLOW  = 2'd1;
   localparam logic [1:0] ST_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic                        req_type;
      logic signed [DataWidth-1:0] push_value;
   } mst_req_type;

   typedef struct packed {
      logic signed [DataWidth-1:0] top_value;
      logic signed [DataWidth-1:0] min_value;
      logic [CountWidth-1:0]       entry_count;
      logic                        is_empty;
      logic [1:0]                  status;
   } mst_rsp_type;

   // one stack slot: the pushed value and the minimum up to and including it
   typedef struct packed {
      logic signed [DataWidth-1:0] value;
      logic signed [DataWidth-1:0] run_min;
   } mst_entry_type;

endpackage : mst_pkg
`default_nettype wire

FILE: src/min_tracking_stack_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_tracking_stack_top: bounded signed stack with running minimum
// Push or pop one word per request beat; every beat returns one response beat
// with the new top, the minimum of all held values, the count and a status.
//
// Channels: req_* carries {req_type, push_value}; rsp_* carries the result.
//   A beat moves when valid is high and stall is low.
// Response: push, overflow push, underflow pop and a pop that empties the
//   stack answer in the cycle after acceptance. A pop that leaves entries
//   answers later: the new top comes from the slot memory, whose read data
//   is registered, in state S_FILL, and then the response is registered.
// Flow: one push per cycle unless rsp stalls; req_stall holds requests in S_FILL.
// The top slot is held in registers, so pushes never read the memory.
// Reset: the stack is empty and no response is pending; memory contents are
//   not cleared since only slots below the count are ever read.
// Rsp stall: the response holds in its register; req_stall rises until the
//   response beat is taken (a new request is accepted in that same cycle).
// ----------------------------------------------------------------------------
module min_tracking_stack_top
   import mst_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire mst_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      mst_rsp_type rsp_data
);

   localparam int unsigned AW = $clog2(STACK_DEPTH);
   localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

   typedef enum logic {
      S_IDLE,
      S_FILL
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] depth_ff, depth_in;
   mst_entry_type top_ff, top_in;
   logic          rsp_valid_ff, rsp_valid_in;
   mst_rsp_type   rsp_ff, rsp_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   mst_entry_type wr_data;
   logic          rd_en;
   logic [AW-1:0] rd_addr;
   mst_entry_type rd_data;
   logic signed [DataWidth-1:0] new_min;

   function automatic mst_rsp_type make_rsp(input mst_entry_type top,
                                            input logic [CW-1:0] count,
                                            input logic [1:0]    status);
      mst_rsp_type r;
      r.top_value   = top.value;
      r.min_value   = top.run_min;
      r.entry_count = CountWidth'(count);
      r.is_empty    = (count == '0);
      r.status      = status;
      return r;
   endfunction

   mst_store #(
      .Depth     (STACK_DEPTH),
      .AddrWidth (AW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_stall = (state_ff != S_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign full      = (depth_ff == CW'(STACK_DEPTH));
   assign empty     = (depth_ff == '0);

   // new slot minimum: the value itself on an empty stack, else the smaller
   assign new_min = (empty || (req_data.push_value < top_ff.run_min)) ?
                    req_data.push_value : top_ff.run_min;

   always_comb begin
      state_in     = state_ff;
      depth_in     = depth_ff;
      top_in       = top_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      wr_en        = 1'b0;
      wr_addr      = AW'(depth_ff);
      wr_data      = '{value: req_data.push_value, run_min: new_min};
      rd_en        = 1'b0;
      rd_addr      = AW'(depth_ff - CW'(2));

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               case (req_data.req_type)
                  OP_PUSH: begin
                     rsp_valid_in = 1'b1;
                     if (full) begin
                        rsp_in = make_rsp(top_ff, depth_ff, ST_OVERFLOW);
                     end else begin
                        wr_en    = 1'b1;
                        top_in   = wr_data;
                        depth_in = depth_ff + CW'(1);
                        rsp_in   = make_rsp(wr_data, depth_ff + CW'(1), ST_OK);
                     end
                  end
                  OP_POP: begin
                     if (empty) begin
                        rsp_valid_in = 1'b1;
                        rsp_in       = make_rsp('0, '0, ST_UNDERFLOW);
                     end else if (depth_ff == CW'(1)) begin
                        rsp_valid_in = 1'b1;
                        depth_in     = '0;
                        top_in       = '0;
                        rsp_in       = make_rsp('0, '0, ST_OK);
                     end else begin
                        // fetch the slot below the top; it becomes the new top in S_FILL
                        rd_en    = 1'b1;
                        depth_in = depth_ff - CW'(1);
                        state_in = S_FILL;
                     end
                  end
                  default: begin
                     rsp_valid_in = rsp_valid_ff && rsp_stall;
                  end
               endcase
            end
         end
         S_FILL: begin
            top_in       = rd_data;
            rsp_valid_in = 1'b1;
            rsp_in       = make_rsp(rd_data, depth_ff, ST_OK);
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_ff <= top_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule : min_tracking_stack_top
`default_nettype wire

FILE: src/mst_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mst_store: stack slot memory
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module mst_store
   import mst_pkg::*;
#(
   parameter int unsigned Depth     = 64,
   parameter int unsigned AddrWidth = 6
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [AddrWidth-1:0] wr_addr,
   input  wire mst_entry_type        wr_data,
   input  wire logic                 rd_en,
   input  wire logic [AddrWidth-1:0] rd_addr,
   output      mst_entry_type        rd_data
);

   mst_entry_type mem [Depth];
   mst_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : mst_store
`default_nettype wire

FILE: tb/mst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mst_checker: response predictor and scoreboard for the min-tracking stack
// Watches both channels. Each accepted request beat is run through a local
// copy of the stack, and the resulting view (top, minimum, count, empty flag,
// status) is queued. Each accepted response beat is compared field by field
// with the oldest queued view.
// ----------------------------------------------------------------------------
module mst_checker
   import mst_pkg::*;
#(
   parameter int unsigned STACK_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire mst_req_type req_data,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire mst_rsp_type rsp_data,
   output int unsigned      mismatch_count,
   output int unsigned      open_count
);

   localparam int unsigned ReportLimit = 10;

   mst_entry_type stack_slots [STACK_DEPTH];
   int unsigned   slot_count = 0;
   int unsigned   fail_total = 0;
   mst_rsp_type   stack_view_q [$];

   // apply one request to the local stack and queue the view it leaves behind
   task automatic predict_stack_op(input mst_req_type beat);
      mst_rsp_type   view;
      mst_entry_type slot;
      view        = '0;
      view.status = ST_OK;
      if (beat.req_type == OP_PUSH) begin
         if (slot_count >= STACK_DEPTH) begin
            view.status = ST_OVERFLOW;
         end else begin
            slot.value   = beat.push_value;
            slot.run_min = beat.push_value;
            if (slot_count > 0 &&
                !(beat.push_value < stack_slots[slot_count - 1].run_min)) begin
               slot.run_min = stack_slots[slot_count - 1].run_min;
            end
            stack_slots[slot_count] = slot;
            slot_count++;
         end
      end else if (slot_count == 0) begin
         view.status = ST_UNDERFLOW;
      end else begin
         slot_count--;
      end
      if (slot_count > 0) begin
         view.top_value = stack_slots[slot_count - 1].value;
         view.min_value = stack_slots[slot_count - 1].run_min;
      end
      view.entry_count = slot_count[CountWidth-1:0];
      view.is_empty    = (slot_count == 0);
      stack_view_q.push_back(view);
   endtask

   always @(posedge clock) begin : watch_channels
      mst_rsp_type want;
      if (reset) begin
         slot_count = 0;
         stack_view_q.delete();
         open_count <= 0;
      end else begin
         // a response never belongs to a request taken on the same edge
         if (rsp_valid && !rsp_stall) begin
            if (stack_view_q.size() == 0) begin
               if (fail_total < ReportLimit) begin
                  $display("%0t: response beat with nothing expected: %p", $time, rsp_data);
               end
               fail_total++;
            end else begin
               want = stack_view_q.pop_front();
               if (rsp_data.top_value !== want.top_value ||
                   rsp_data.min_value !== want.min_value ||
                   rsp_data.entry_count !== want.entry_count ||
                   rsp_data.is_empty !== want.is_empty ||
                   rsp_data.status !== want.status) begin
                  if (fail_total < ReportLimit) begin
                     $display("%0t: mismatch top %0d/%0d min %0d/%0d count %0d/%0d",
                              $time, want.top_value, rsp_data.top_value,
                              want.min_value, rsp_data.min_value,
                              want.entry_count, rsp_data.entry_count);
                     $display("   empty %0b/%0b status %0d/%0d (expected/actual)",
                              want.is_empty, rsp_data.is_empty,
                              want.status, rsp_data.status);
                  end
                  fail_total++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            predict_stack_op(req_data);
         end
         open_count <= stack_view_q.size();
      end
      mismatch_count <= fail_total;
   end

endmodule : mst_checker

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the min-tracking stack
// Drives a short directed sequence (underflow, extremes, ties, emptying pops),
// a full fill into overflow and a full drain, then random segments biased
// toward pushing, popping or churning. The sender runs in bursts with gaps,
// the receiver stalls in changing patterns; mst_checker does the comparing.
// ----------------------------------------------------------------------------
module tb_top;
   import mst_pkg::*;

   localparam int unsigned STACK_DEPTH = 64;
   localparam int unsigned RandomItems = 1250;
   localparam int unsigned CycleLimit  = 400000;
   localparam int unsigned TailCycles  = 8;

   typedef enum int unsigned {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_PERIODIC
   } stall_kind_type;

   logic           clock     = 1'b0;
   logic           reset     = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_stall;
   mst_req_type    req_data  = '0;
   logic           rsp_valid;
   logic           rsp_stall = 1'b0;
   mst_rsp_type    rsp_data;

   int unsigned    mismatch_count;
   int unsigned    open_count;
   int unsigned    cycle_count = 0;
   int unsigned    burst_left  = 0;
   int unsigned    stall_left  = 0;
   stall_kind_type stall_kind  = STALL_NONE;

   always #4 clock = ~clock;

   min_tracking_stack_top #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   mst_checker #(
      .STACK_DEPTH(STACK_DEPTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data      (req_data),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_data      (rsp_data),
      .mismatch_count(mismatch_count),
      .open_count    (open_count)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // receiver: switch stall pattern every so often
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0) begin
            stall_kind = stall_kind_type'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 200);
         end
         stall_left--;
         case (stall_kind)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((stall_left % 5) < 2);
         endcase
      end
   end

   function automatic logic signed [DataWidth-1:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2:       return '0;
         3:       return -1;
         4, 5:    return int'($urandom_range(0, 16)) - 8;
         default: return $urandom();
      endcase
   endfunction

   // hold the beat until it is taken
   task automatic send_beat(input logic op, input logic signed [DataWidth-1:0] value);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         if ($urandom_range(0, 3) != 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{req_type: op, push_value: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   initial begin
      int unsigned sent;
      int unsigned seg_len;
      int unsigned push_pct;
      int unsigned seg_idx;
      logic        op;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // pops on an empty stack
      send_beat(OP_POP, pick_value());
      send_beat(OP_POP, 32'sh7FFF_FFFF);
      // extremes, then pop back through them until empty and beyond
      send_beat(OP_PUSH, 32'sh7FFF_FFFF);
      send_beat(OP_PUSH, 32'sh8000_0000);
      send_beat(OP_PUSH, 0);
      send_beat(OP_POP, 0);
      send_beat(OP_POP, -1);
      send_beat(OP_POP, 0);
      send_beat(OP_POP, 0);
      // ties on the minimum and signed ordering around zero
      send_beat(OP_PUSH, 5);
      send_beat(OP_PUSH, 5);
      send_beat(OP_PUSH, -7);
      send_beat(OP_PUSH, -7);
      send_beat(OP_PUSH, 3);
      send_beat(OP_PUSH, -1);
      repeat (6) send_beat(OP_POP, pick_value());
      send_beat(OP_POP, 0);
      wait_quiet();

      // first a full fill past overflow, then a full drain past underflow
      sent    = 0;
      seg_idx = 0;
      while (sent < RandomItems) begin
         if (seg_idx == 0) begin
            push_pct = 100;
            seg_len  = STACK_DEPTH + 6;
         end else if (seg_idx == 1) begin
            push_pct = 0;
            seg_len  = STACK_DEPTH + 6;
         end else begin
            case ($urandom_range(0, 3))
               0:       push_pct = 90;
               1:       push_pct = 10;
               2:       push_pct = 50;
               default: push_pct = 65;
            endcase
            seg_len = $urandom_range(20, 120);
         end
         repeat (seg_len) begin
            op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
            send_beat(op, pick_value());
            sent++;
         end
         seg_idx++;
         if ($urandom_range(0, 3) == 0) begin
            wait_quiet();
         end
      end

      wait_quiet();
      repeat (TailCycles) @(posedge clock);
      if (mismatch_count == 0 && open_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule : tb_top
